// ===== sv/tcld_pkg.sv =====
// Shared types and constants for the text command line decoder.
// Holds keyword tables, parse phase and command codes; depends on nothing.
`default_nettype none

package tcld_pkg;

  typedef logic [7:0] byte_t;

  // Command codes carried in the result
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_PING     = 4'd1,
    CMD_CENTER   = 4'd2,
    CMD_STOP     = 4'd3,
    CMD_STATUS   = 4'd4,
    CMD_ANGLE    = 4'd5,
    CMD_LED_ON   = 4'd6,
    CMD_LED_OFF  = 4'd7,
    CMD_STATE    = 4'd8,
    CMD_BUZZ_ON  = 4'd9,
    CMD_BUZZ_OFF = 4'd10,
    CMD_BEEP     = 4'd11
  } tcld_cmd_e;

  typedef enum logic [2:0] {
    PH_LEAD,      // skipping leading blanks
    PH_HEAD,      // keyword or prefix token
    PH_ARG_LEAD,  // blanks after the colon
    PH_ARG,       // payload token
    PH_DEAD       // line can no longer match
  } tcld_phase_e;

  typedef enum logic [1:0] {
    PFX_ANGLE,
    PFX_LED,
    PFX_STATE,
    PFX_BUZZER
  } tcld_prefix_e;

  // Device modes for the state command
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_LOCK   = 2'd2;
  localparam logic [1:0] MODE_LOST   = 2'd3;

  // Head token candidates: exact keywords then colon prefixes
  localparam int HEAD_N    = 9;
  localparam int HK_PING   = 0;
  localparam int HK_CENTER = 1;
  localparam int HK_STOP   = 2;
  localparam int HK_STATUS = 3;
  localparam int HK_STATUSQ = 4;
  localparam int HK_ANGLE  = 5;
  localparam int HK_LED    = 6;
  localparam int HK_STATE  = 7;
  localparam int HK_BUZZER = 8;

  localparam byte_t HEAD_TEXT [HEAD_N][8] = '{
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "E", "N", "T", "E", "R", 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
    '{"S", "T", "A", "T", "U", "S", "?", 8'h00},
    '{"A", "N", "G", "L", "E", 8'h00, 8'h00, 8'h00},
    '{"L", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "T", "E", 8'h00, 8'h00, 8'h00},
    '{"B", "U", "Z", "Z", "E", "R", 8'h00, 8'h00}
  };
  localparam logic [3:0] HEAD_LEN [HEAD_N] = '{
    4'd4, 4'd6, 4'd4, 4'd6, 4'd7, 4'd5, 4'd3, 4'd5, 4'd6
  };

  // Payload word candidates
  localparam int WORD_N    = 7;
  localparam int WK_ON     = 0;
  localparam int WK_OFF    = 1;
  localparam int WK_IDLE   = 2;
  localparam int WK_SEARCH = 3;
  localparam int WK_LOCK   = 4;
  localparam int WK_LOST   = 5;
  localparam int WK_BEEP   = 6;

  localparam byte_t WORD_TEXT [WORD_N][8] = '{
    '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "D", "L", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "E", "A", "R", "C", "H", 8'h00, 8'h00},
    '{"L", "O", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "E", "E", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] WORD_LEN [WORD_N] = '{
    4'd2, 4'd3, 4'd4, 4'd6, 4'd4, 4'd4, 4'd4
  };

  // Angle magnitude saturates here; anything above 32768 is already invalid
  localparam logic [16:0] MAG_CAP     = 17'd40000;
  localparam logic [16:0] MAG_MAX_POS = 17'd32767;
  localparam logic [16:0] MAG_MAX_NEG = 17'd32768;

  // Parse state carried from byte to byte of a line
  typedef struct packed {
    tcld_phase_e         phase;
    logic [HEAD_N-1:0]   head_hits;
    logic [WORD_N-1:0]   word_hits;
    logic [3:0]          pos;
    tcld_prefix_e        prefix;
    logic [16:0]         mag;
    logic                neg;
    logic                digit_seen;
    logic                angle_bad;
    logic                gap;
  } tcld_state_t;

  localparam tcld_state_t STATE_INIT = '{
    phase:      PH_LEAD,
    head_hits:  '1,
    word_hits:  '1,
    pos:        4'd0,
    prefix:     PFX_ANGLE,
    mag:        17'd0,
    neg:        1'b0,
    digit_seen: 1'b0,
    angle_bad:  1'b0,
    gap:        1'b0
  };

  typedef struct packed {
    tcld_cmd_e   cmd;
    logic [15:0] angle;
    logic [1:0]  mode;
  } tcld_result_t;

endpackage

`default_nettype wire

// ===== sv/tcld_scan.sv =====
// Per-byte scanner: holds the line's parse state and computes its next value.
// Uses tcld_pkg for the keyword tables and the state struct.
`default_nettype none

module tcld_scan #(
  parameter int LINE_BUFFER_BYTES = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire  [7:0]          char_i,
  input  wire                 last_i,
  output tcld_pkg::tcld_state_t next_o
);
  import tcld_pkg::*;

  localparam int CntW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CntW-1:0] Limit = CntW'(LINE_BUFFER_BYTES - 1);

  tcld_state_t     st_q, st_d;
  logic [CntW-1:0] cnt_q;
  logic            ended_q;
  logic            counted, blank, head_step, arg_step;
  logic [3:0]      pos_inc;
  logic [20:0]     mag_x;

  always_comb begin
    counted   = (cnt_q < Limit) && !ended_q && (char_i != 8'h00);
    blank     = (char_i == 8'd32) || ((char_i >= 8'd9) && (char_i <= 8'd13));
    pos_inc   = (st_q.pos == 4'hF) ? st_q.pos : st_q.pos + 4'd1;
    mag_x     = ({4'b0, st_q.mag} << 3) + ({4'b0, st_q.mag} << 1) + 21'(char_i[3:0]);
    head_step = 1'b0;
    arg_step  = 1'b0;
    st_d      = st_q;

    if (counted) begin
      case (st_q.phase)
        PH_LEAD: begin
          if (!blank) begin
            st_d.phase = PH_HEAD;
            head_step  = 1'b1;
          end
        end
        PH_HEAD: begin
          if (blank) st_d.gap = 1'b1;
          else if (st_q.gap) st_d.phase = PH_DEAD;
          else head_step = 1'b1;
        end
        PH_ARG_LEAD: begin
          if (!blank) begin
            st_d.phase = PH_ARG;
            arg_step   = 1'b1;
          end
        end
        PH_ARG: begin
          if (blank) st_d.gap = 1'b1;
          else if (st_q.gap) st_d.phase = PH_DEAD;
          else arg_step = 1'b1;
        end
        default: ;
      endcase
    end

    if (head_step) begin
      if (char_i == ":") begin
        // the first colon closes the head; it must end a prefix exactly
        st_d.phase = PH_ARG_LEAD;
        st_d.pos   = 4'd0;
        if (st_q.head_hits[HK_ANGLE] && st_q.pos == HEAD_LEN[HK_ANGLE])
          st_d.prefix = PFX_ANGLE;
        else if (st_q.head_hits[HK_LED] && st_q.pos == HEAD_LEN[HK_LED])
          st_d.prefix = PFX_LED;
        else if (st_q.head_hits[HK_STATE] && st_q.pos == HEAD_LEN[HK_STATE])
          st_d.prefix = PFX_STATE;
        else if (st_q.head_hits[HK_BUZZER] && st_q.pos == HEAD_LEN[HK_BUZZER])
          st_d.prefix = PFX_BUZZER;
        else
          st_d.phase = PH_DEAD;
      end else begin
        for (int k = 0; k < HEAD_N; k++) begin
          st_d.head_hits[k] = st_q.head_hits[k] && (st_q.pos < HEAD_LEN[k]) &&
                              (char_i == HEAD_TEXT[k][st_q.pos[2:0]]);
        end
        st_d.pos = pos_inc;
      end
    end

    if (arg_step) begin
      for (int j = 0; j < WORD_N; j++) begin
        st_d.word_hits[j] = st_q.word_hits[j] && (st_q.pos < WORD_LEN[j]) &&
                            (char_i == WORD_TEXT[j][st_q.pos[2:0]]);
      end
      st_d.pos = pos_inc;
      if (st_q.pos == 4'd0 && (char_i == "+" || char_i == "-")) begin
        st_d.neg = (char_i == "-");
      end else if (char_i >= "0" && char_i <= "9") begin
        st_d.digit_seen = 1'b1;
        st_d.mag = (mag_x > {4'b0, MAG_CAP}) ? MAG_CAP : mag_x[16:0];
      end else begin
        st_d.angle_bad = 1'b1;
      end
    end
  end

  assign next_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= STATE_INIT;
      cnt_q   <= '0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        // start the next line from scratch
        st_q    <= STATE_INIT;
        cnt_q   <= '0;
        ended_q <= 1'b0;
      end else begin
        st_q <= st_d;
        if (cnt_q < Limit) begin
          cnt_q <= cnt_q + 1'b1;
          if (char_i == 8'h00) ended_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcld_resolve.sv =====
// Line-end resolver: turns the final parse state into a command result.
// Combinational; uses tcld_pkg for the tables, state and result types.
`default_nettype none

module tcld_resolve (
  input  tcld_pkg::tcld_state_t  state_i,
  output tcld_pkg::tcld_result_t result_o
);
  import tcld_pkg::*;

  logic [HEAD_N-1:0] head_done;
  logic [WORD_N-1:0] word_done;
  logic              angle_ok;
  logic [16:0]       neg_mag;

  always_comb begin
    for (int k = 0; k < HEAD_N; k++)
      head_done[k] = state_i.head_hits[k] && (state_i.pos == HEAD_LEN[k]);
    for (int j = 0; j < WORD_N; j++)
      word_done[j] = state_i.word_hits[j] && (state_i.pos == WORD_LEN[j]);

    neg_mag  = 17'd0 - state_i.mag;
    angle_ok = state_i.digit_seen && !state_i.angle_bad &&
               (state_i.neg ? (state_i.mag <= MAG_MAX_NEG) : (state_i.mag <= MAG_MAX_POS));

    result_o = '{cmd: CMD_NONE, angle: 16'd0, mode: MODE_IDLE};

    case (state_i.phase)
      PH_HEAD: begin
        if (head_done[HK_PING]) result_o.cmd = CMD_PING;
        else if (head_done[HK_CENTER]) result_o.cmd = CMD_CENTER;
        else if (head_done[HK_STOP]) result_o.cmd = CMD_STOP;
        else if (head_done[HK_STATUS] || head_done[HK_STATUSQ]) result_o.cmd = CMD_STATUS;
      end
      PH_ARG: begin
        case (state_i.prefix)
          PFX_ANGLE: begin
            if (angle_ok) begin
              result_o.cmd   = CMD_ANGLE;
              result_o.angle = state_i.neg ? neg_mag[15:0] : state_i.mag[15:0];
            end
          end
          PFX_LED: begin
            if (word_done[WK_ON]) result_o.cmd = CMD_LED_ON;
            else if (word_done[WK_OFF]) result_o.cmd = CMD_LED_OFF;
          end
          PFX_STATE: begin
            if (word_done[WK_IDLE]) begin
              result_o.cmd = CMD_STATE;
              result_o.mode = MODE_IDLE;
            end else if (word_done[WK_SEARCH]) begin
              result_o.cmd = CMD_STATE;
              result_o.mode = MODE_SEARCH;
            end else if (word_done[WK_LOCK]) begin
              result_o.cmd = CMD_STATE;
              result_o.mode = MODE_LOCK;
            end else if (word_done[WK_LOST]) begin
              result_o.cmd = CMD_STATE;
              result_o.mode = MODE_LOST;
            end
          end
          PFX_BUZZER: begin
            if (word_done[WK_ON]) result_o.cmd = CMD_BUZZ_ON;
            else if (word_done[WK_OFF]) result_o.cmd = CMD_BUZZ_OFF;
            else if (word_done[WK_BEEP]) result_o.cmd = CMD_BEEP;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/text_command_line_decoder_core.sv =====
// Text command line decoder, top level: input register, scanner, resolver
// and result register. Depends on tcld_pkg, tcld_scan and tcld_resolve.
//
// Usage:
//   The slave stream carries one byte of a command line per request
//   (tdata = char_byte, tlast = line_end). Each byte is matched on the fly
//   against the keyword and prefix tables; no line buffer is kept. On the
//   byte with tlast set, the master stream delivers one result request:
//   cmd_code, angle_value and mode_value. Bytes without tlast produce
//   nothing. Only the first LINE_BUFFER_BYTES-1 bytes of a line count, and
//   a zero byte ends the content of its line.
//   Throughput: one byte per cycle, set by the scanner update, except while
//   a line end waits for the result slot. Result path: the last byte waits
//   in the input register until the result slot is free, then the result
//   register loads.
//   Stall: while a result waits on m_axis_tready_i the input register still
//   takes bytes of the next line; only a second line end holds there, and
//   then s_axis_tready_o drops until the result is taken.
//   Reset: asynchronous, active low; clears both registers' valid flags and
//   restarts the parse at the beginning of a line.
`default_nettype none

module text_command_line_decoder_core #(
  parameter int LINE_BUFFER_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  wire         s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [3:0] cmd_code, [19:4] angle_value,
                                        // [21:20] mode_value, [23:22] zero
);
  import tcld_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Result register
  logic         out_valid_q;
  tcld_result_t out_q;

  logic         out_free, adv, load;
  tcld_state_t  next_state;
  tcld_result_t result;

  // advance the held byte unless it ends a line and the result slot is full
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  tcld_scan #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .next_o (next_state)
  );

  tcld_resolve u_resolve (
    .state_i  (next_state),
    .result_o (result)
  );

  // capture the result on a line end; drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) out_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.mode, out_q.angle, out_q.cmd};

  // A held byte that cannot advance keeps its value
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_char_q) && $stable(in_last_q))
    else $error("input register lost a stalled byte");

  // A new result only follows an advanced line end
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result appeared without a line end");

  // Input side stalls only behind a blocked line end
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a pending result");

  // Angle and mode fields are zero outside their commands
  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.cmd == CMD_ANGLE || out_q.angle == 16'd0) &&
                    (out_q.cmd == CMD_STATE || out_q.mode == MODE_IDLE))
    else $error("payload field set for the wrong command");

endmodule

`default_nettype wire

// ===== bench/tb_text_command_line_decoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_command_line_decoder_core: directed command lines, then
// random lines under three idle patterns and one long result back-pressure hold.
// Depends on tcld_pkg and the core; expected commands come from typed rows or a predictor.

module tb_text_command_line_decoder_core;
  import tcld_pkg::*;

  localparam int LINE_BYTES    = 64;
  localparam int LINE_LIMIT    = LINE_BYTES - 1;  // bytes of a line that count
  localparam int PHASE_BYTES   = 40;              // random bytes per idle pattern, at least
  localparam int HOLD_CYCLES   = 300;             // long receiver hold-off
  localparam int STALL_LIMIT   = 3000;            // cycles without any request moving
  localparam int DRAIN_CYCLES  = 8;

  // Who idles: sender 33 / receiver 66, then the reverse, then nobody
  typedef enum logic [1:0] {
    RX_SLOW,
    TX_SLOW,
    NO_IDLE
  } idle_mode_e;

  typedef byte_t byte_q_t[$];

  // One directed line. A '~' in text stands for a zero byte. A nonempty tail
  // pads the text with blanks up to the line limit and appends the tail, so
  // the tail lands past the bytes that count.
  typedef struct {
    string       text;
    string       tail;
    bit          typed;
    tcld_cmd_e   cmd;
    logic [15:0] angle;
    logic [1:0]  mode;
  } line_case_t;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [7:0]  s_data   = 8'd0;
  logic        s_last   = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;

  idle_mode_e  idle_mode = RX_SLOW;
  int          tx_idle_pct = 33;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mismatch_count = 0;

  // Predictor state: content bytes of the current line and its counters
  byte_t        cmd_text[$];
  int           line_bytes_seen = 0;
  bit           zero_seen = 1'b0;
  tcld_result_t expected_cmds[$];
  tcld_result_t oldest_cmd;

  string head_words [5]  = '{"PING", "CENTER", "STOP", "STATUS", "STATUS?"};
  string state_words [4] = '{"IDLE", "SEARCH", "LOCK", "LOST"};
  string buzz_words [3]  = '{"ON", "OFF", "BEEP"};
  byte_t blank_bytes [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};

  line_case_t directed_lines [] = '{
    '{"PING",              "",   1'b1, CMD_PING,  16'd0,     MODE_IDLE},
    '{"  CENTER\t",        "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STOP",              "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STATUS",            "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{" STATUS? ",         "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE:32767",       "",   1'b1, CMD_ANGLE, 16'h7FFF,  MODE_IDLE},
    '{"ANGLE: -32768",     "",   1'b1, CMD_ANGLE, 16'h8000,  MODE_IDLE},
    '{"ANGLE:32768",       "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE:-32769",      "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE:+0",          "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE:-",           "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE:99999999999", "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ANGLE :5",          "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"LED:ON",            "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"LED:  OFF",         "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STATE:IDLE",        "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STATE:SEARCH",      "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STATE:\tLOCK",      "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STATE:LOST\n",      "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"BUZZER:ON",         "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"BUZZER:OFF",        "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"BUZZER: BEEP",      "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"ping",              "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{" ",                 "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"~",                 "",   1'b1, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"STOP~JUNK",         "",   1'b0, CMD_NONE,  16'd0,     MODE_IDLE},
    '{"PING",              "XY", 1'b0, CMD_NONE,  16'd0,     MODE_IDLE}
  };

  text_command_line_decoder_core #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(byte_t c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // True when cmd_text[lo..hi) spells the word exactly
  function automatic bit span_eq(int lo, int hi, string word);
    if (hi - lo != word.len()) return 1'b0;
    for (int i = 0; i < word.len(); i++) begin
      if (cmd_text[lo + i] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Signed decimal with optional sign; any stray character or a value out of
  // 16-bit range rejects the whole payload
  function automatic bit parse_angle(int lo, int hi, output logic [15:0] bits);
    bit          neg;
    int unsigned mag;
    int          i;
    neg  = 1'b0;
    mag  = 0;
    i    = lo;
    bits = '0;
    if (i < hi && (cmd_text[i] == "+" || cmd_text[i] == "-")) begin
      neg = cmd_text[i] == "-";
      i++;
    end
    if (i >= hi) return 1'b0;
    while (i < hi) begin
      if (cmd_text[i] < "0" || cmd_text[i] > "9") return 1'b0;
      mag = mag * 10 + (cmd_text[i] - "0");
      if (mag > 40000) mag = 40000;
      i++;
    end
    if (neg ? mag > 32768 : mag > 32767) return 1'b0;
    bits = neg ? 16'(17'h10000 - mag) : 16'(mag);
    return 1'b1;
  endfunction

  function automatic tcld_result_t decode_command_text();
    tcld_result_t r;
    int           lo;
    int           hi;
    int           sep;
    int           p;
    logic [15:0]  a;
    r.cmd   = CMD_NONE;
    r.angle = '0;
    r.mode  = MODE_IDLE;
    lo = 0;
    hi = cmd_text.size();
    while (hi > lo && is_blank(cmd_text[hi - 1])) hi--;
    while (lo < hi && is_blank(cmd_text[lo])) lo++;
    if (lo == hi) return r;
    if (span_eq(lo, hi, "PING")) r.cmd = CMD_PING;
    else if (span_eq(lo, hi, "CENTER")) r.cmd = CMD_CENTER;
    else if (span_eq(lo, hi, "STOP")) r.cmd = CMD_STOP;
    else if (span_eq(lo, hi, "STATUS?") || span_eq(lo, hi, "STATUS")) r.cmd = CMD_STATUS;
    else begin
      sep = lo;
      while (sep < hi && cmd_text[sep] != ":") sep++;
      if (sep == hi) return r;
      p = sep + 1;
      while (p < hi && is_blank(cmd_text[p])) p++;
      if (span_eq(lo, sep, "ANGLE")) begin
        if (parse_angle(p, hi, a)) begin
          r.cmd   = CMD_ANGLE;
          r.angle = a;
        end
      end else if (span_eq(lo, sep, "LED")) begin
        if (span_eq(p, hi, "ON")) r.cmd = CMD_LED_ON;
        else if (span_eq(p, hi, "OFF")) r.cmd = CMD_LED_OFF;
      end else if (span_eq(lo, sep, "STATE")) begin
        if (span_eq(p, hi, "IDLE")) begin
          r.cmd = CMD_STATE; r.mode = MODE_IDLE;
        end else if (span_eq(p, hi, "SEARCH")) begin
          r.cmd = CMD_STATE; r.mode = MODE_SEARCH;
        end else if (span_eq(p, hi, "LOCK")) begin
          r.cmd = CMD_STATE; r.mode = MODE_LOCK;
        end else if (span_eq(p, hi, "LOST")) begin
          r.cmd = CMD_STATE; r.mode = MODE_LOST;
        end
      end else if (span_eq(lo, sep, "BUZZER")) begin
        if (span_eq(p, hi, "ON")) r.cmd = CMD_BUZZ_ON;
        else if (span_eq(p, hi, "OFF")) r.cmd = CMD_BUZZ_OFF;
        else if (span_eq(p, hi, "BEEP")) r.cmd = CMD_BEEP;
      end
    end
    return r;
  endfunction

  // Absorb one byte; on a line end hand back the decoded command and restart
  task automatic absorb_line_byte(byte_t c, bit last, output bit got,
                                  output tcld_result_t cmd);
    got = 1'b0;
    cmd = '0;
    if (line_bytes_seen < LINE_LIMIT) begin
      line_bytes_seen++;
      if (!zero_seen) begin
        if (c == 8'd0) zero_seen = 1'b1;
        else cmd_text.push_back(c);
      end
    end
    if (last) begin
      got = 1'b1;
      cmd = decode_command_text();
      cmd_text.delete();
      line_bytes_seen = 0;
      zero_seen = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random lines
  // ---------------------------------------------------------------------------

  function automatic void push_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void push_blanks(ref byte_q_t q);
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) q.push_back(blank_bytes[$urandom_range(0, 5)]);
  endfunction

  function automatic string random_angle_text();
    int unsigned mag;
    string       s;
    case ($urandom_range(0, 4))
      0:       mag = $urandom_range(0, 32768);
      1:       mag = 32766 + $urandom_range(0, 3);  // straddle both limits
      2:       mag = $urandom_range(0, 99);
      3:       mag = $urandom_range(0, 99999999);
      default: mag = $urandom_range(30000, 42000);
    endcase
    s = $sformatf("%0d", mag);
    if ($urandom_range(0, 7) == 0) s = {"00", s};
    case ($urandom_range(0, 3))
      0, 1:    s = {"-", s};
      2:       s = {"+", s};
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) s = ($urandom_range(0, 1) != 0) ? "-" : "";
    if ($urandom_range(0, 15) == 0) s = {s, "x"};
    return s;
  endfunction

  // Mostly well-formed commands with random content, some corrupted, some noise
  function automatic byte_q_t random_line();
    byte_q_t q;
    int      kind;
    int      pad_to;
    q = {};
    kind = $urandom_range(0, 15);
    if (kind <= 12) begin
      push_blanks(q);
      case ($urandom_range(0, 9))
        0, 1: push_text(q, head_words[$urandom_range(0, 4)]);
        2, 3, 4: begin
          push_text(q, "ANGLE:");
          push_blanks(q);
          push_text(q, random_angle_text());
        end
        5: begin
          push_text(q, "LED:");
          push_blanks(q);
          push_text(q, ($urandom_range(0, 1) != 0) ? "ON" : "OFF");
        end
        6, 7: begin
          push_text(q, "STATE:");
          push_blanks(q);
          push_text(q, state_words[$urandom_range(0, 3)]);
        end
        default: begin
          push_text(q, "BUZZER:");
          push_blanks(q);
          push_text(q, buzz_words[$urandom_range(0, 2)]);
        end
      endcase
      push_blanks(q);
      if (q.size() == 0) q.push_back(8'd32);
      // break the line: one random byte, or a zero byte that cuts it short
      if (kind == 11) q[$urandom_range(0, q.size() - 1)] = byte_t'($urandom_range(0, 255));
      if (kind == 12) q.insert($urandom_range(0, q.size()), 8'd0);
    end else if (kind == 15 && $urandom_range(0, 2) == 0) begin
      // overlong: junk lands around the last byte that counts
      push_text(q, head_words[$urandom_range(0, 4)]);
      pad_to = $urandom_range(LINE_LIMIT - 4, LINE_LIMIT);
      while (q.size() < pad_to) q.push_back(8'd32);
      repeat ($urandom_range(1, 4)) q.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) q.push_back(byte_t'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer each byte until taken, idling at random between bytes.
  // The expected command is queued as the last byte is offered, so it always
  // stands before the result it belongs to.
  // ---------------------------------------------------------------------------
  task automatic send_line(byte_q_t bytes, bit use_typed, tcld_result_t typed_cmd);
    bit           got;
    bit           last;
    tcld_result_t predicted;
    for (int i = 0; i < bytes.size(); i++) begin
      last = (i == bytes.size() - 1);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
      s_valid <= 1'b1;
      s_data  <= bytes[i];
      s_last  <= last;
      absorb_line_byte(bytes[i], last, got, predicted);
      if (got) expected_cmds.push_back(use_typed ? typed_cmd : predicted);
      do @(posedge clk_i); while (!s_axis_tready_o);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random tready per idle pattern; once, on entering the no-idle
  // pattern, hold off long enough that the core backs up and stalls its input
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (idle_mode == NO_IDLE && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      case (idle_mode)
        RX_SLOW: m_tready <= $urandom_range(0, 99) >= 66;
        TX_SLOW: m_tready <= $urandom_range(0, 99) >= 33;
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Compare each result request with the oldest expected command
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: result %h with no command expected", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        oldest_cmd = expected_cmds.pop_front();
        if (m_axis_tdata_o[3:0] !== oldest_cmd.cmd) begin
          $display("%0t: cmd_code expected %0d got %0d", $time, oldest_cmd.cmd,
                   m_axis_tdata_o[3:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[19:4] !== oldest_cmd.angle) begin
          $display("%0t: angle_value expected %0d got %0d", $time,
                   $signed(oldest_cmd.angle), $signed(m_axis_tdata_o[19:4]));
          mismatch_count++;
        end
        if (m_axis_tdata_o[21:20] !== oldest_cmd.mode) begin
          $display("%0t: mode_value expected %0d got %0d", $time, oldest_cmd.mode,
                   m_axis_tdata_o[21:20]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("text_command_line_decoder_core test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    byte_q_t      lb;
    line_case_t   row;
    tcld_result_t typed_cmd;
    int           sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the first idle pattern
    foreach (directed_lines[r]) begin
      row = directed_lines[r];
      lb = {};
      for (int i = 0; i < row.text.len(); i++)
        lb.push_back(row.text[i] == "~" ? 8'd0 : byte_t'(row.text[i]));
      if (row.tail.len() != 0) begin
        while (lb.size() < LINE_LIMIT) lb.push_back(8'd32);
        push_text(lb, row.tail);
      end
      typed_cmd.cmd   = row.cmd;
      typed_cmd.angle = row.angle;
      typed_cmd.mode  = row.mode;
      send_line(lb, row.typed, typed_cmd);
    end

    // Random lines, one batch per idle pattern
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin idle_mode <= RX_SLOW; tx_idle_pct = 33; end
        1: begin idle_mode <= TX_SLOW; tx_idle_pct = 66; end
        default: begin idle_mode <= NO_IDLE; tx_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        lb = random_line();
        sent += lb.size();
        send_line(lb, 1'b0, '0);
      end
    end
    s_valid <= 1'b0;

    // Drain: wait for every expected command, then a few more cycles
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      $display("%0t: %0d expected commands never arrived", $time, expected_cmds.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("text_command_line_decoder_core test passed");
    end else begin
      $display("text_command_line_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcld_pkg.sv
sv/tcld_scan.sv
sv/tcld_resolve.sv
sv/text_command_line_decoder_core.sv
bench/tb_text_command_line_decoder_core.sv
